// File: hdl/gpx_trackpoint_csv_extractor_macros.svh
// Assertion helpers used by the checker file.
`ifndef GPX_TRACKPOINT_CSV_EXTRACTOR_MACROS_SVH
`define GPX_TRACKPOINT_CSV_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GTCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gtce check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GTCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gtce check failed");

`endif

// File: hdl/gtce_pkg.sv
`default_nettype none
package gtce_pkg;

	localparam int LEVEL_WIDTH_DEF = 8;

	// phase codes
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_LAT   = 3'd1;
	localparam logic [2:0] PH_LON   = 3'd2;
	localparam logic [2:0] PH_ELE   = 3'd3;
	localparam logic [2:0] PH_TIME  = 3'd4;
	localparam logic [2:0] PH_END   = 3'd5;

	// sub-step codes, start tag search
	localparam logic [4:0] SS_IDLE  = 5'd0;
	localparam logic [4:0] ST_NAME  = 5'd1;  // 1..5: next trkpt letter
	localparam logic [4:0] ST_WS    = 5'd6;

	// sub-step codes, attribute search
	localparam logic [4:0] AT_SPACE = 5'd1;
	localparam logic [4:0] AT_N1    = 5'd2;
	localparam logic [4:0] AT_N2    = 5'd3;
	localparam logic [4:0] AT_EQ    = 5'd4;
	localparam logic [4:0] AT_OPEN  = 5'd5;
	localparam logic [4:0] AT_DQ    = 5'd6;
	localparam logic [4:0] AT_SQ    = 5'd7;
	localparam logic [4:0] AT_AFTER = 5'd8;
	localparam logic [4:0] AT_GT    = 5'd9;
	localparam logic [4:0] AT_TAIL  = 5'd10;
	localparam logic [4:0] AT_SKIPD = 5'd11;
	localparam logic [4:0] AT_SKIPS = 5'd12;

	// sub-step codes, element search
	localparam logic [4:0] EL_LT     = 5'd1;
	localparam logic [4:0] EL_NAME   = 5'd2;  // 2..len: next name letter
	localparam logic [4:0] EX_SKIP1  = 5'd8;
	localparam logic [4:0] EX_COPY   = 5'd9;
	localparam logic [4:0] EX_CLT    = 5'd10;
	localparam logic [4:0] EX_CLOSE0 = 5'd11;
	localparam logic [4:0] EX_SKIPF  = 5'd15;
	localparam logic [4:0] EX_QD     = 5'd16;
	localparam logic [4:0] EX_QS     = 5'd17;

	// sub-step codes, end tag search
	localparam logic [4:0] EN_LT    = 5'd1;
	localparam logic [4:0] EN_NAME  = 5'd2;  // 2..6: next trkpt letter
	localparam logic [4:0] EN_LAST  = 5'd6;
	localparam logic [4:0] EN_GT    = 5'd7;

	// emit kinds
	localparam logic [1:0] EMIT_NONE  = 2'd0;
	localparam logic [1:0] EMIT_CHAR  = 2'd1;
	localparam logic [1:0] EMIT_COMMA = 2'd2;

	localparam logic [7:0] CH_SQ    = 8'd39;
	localparam logic [7:0] CH_DQ    = 8'd34;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_LT    = 8'd60;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_EQ    = 8'd61;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [2:0] COMMA_LAST = 3'd6;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] sub;
	} gtce_pos_t;

	typedef struct packed {
		logic       redo;
		logic [1:0] kind;
		logic [7:0] ch;
	} gtce_pass_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		logic r;
		r = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
		return r;
	endfunction

	function automatic logic [7:0] trkpt_char(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0: r = "t";
			3'd1: r = "r";
			3'd2: r = "k";
			3'd3: r = "p";
			3'd4: r = "t";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// letters of lat, lon, ele, time by phase
	function automatic logic [7:0] name_char(input logic [2:0] ph, input logic [2:0] k);
		logic [7:0] r;
		r = 8'd0;
		case (ph)
			PH_LAT: begin
				case (k)
					3'd0: r = "l";
					3'd1: r = "a";
					3'd2: r = "t";
					default: r = 8'd0;
				endcase
			end
			PH_LON: begin
				case (k)
					3'd0: r = "l";
					3'd1: r = "o";
					3'd2: r = "n";
					default: r = 8'd0;
				endcase
			end
			PH_ELE: begin
				case (k)
					3'd0: r = "e";
					3'd1: r = "l";
					3'd2: r = "e";
					default: r = 8'd0;
				endcase
			end
			PH_TIME: begin
				case (k)
					3'd0: r = "t";
					3'd1: r = "i";
					3'd2: r = "m";
					3'd3: r = "e";
					default: r = 8'd0;
				endcase
			end
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] comma_char(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0: r = "&";
			3'd1: r = "c";
			3'd2: r = "o";
			3'd3: r = "m";
			3'd4: r = "m";
			3'd5: r = "a";
			3'd6: r = ";";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/gtce_pass.sv
`default_nettype none
module gtce_pass import gtce_pkg::*; #(
	parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
	input  logic                   en,
	input  logic [7:0]             ch,
	input  gtce_pos_t              pos,
	input  logic [LEVEL_WIDTH-1:0] level,
	output gtce_pos_t              pos_nx,
	output logic [LEVEL_WIDTH-1:0] level_nx,
	output gtce_pass_t             res
);

	logic [7:0]             lc;
	logic                   sp;
	logic [LEVEL_WIDTH-1:0] lvl_up;
	logic [LEVEL_WIDTH-1:0] lvl_dn;
	logic                   tim;
	logic                   lon;
	logic [4:0]             len;
	logic [4:0]             sub;
	logic [4:0]             sub_m1;
	logic [4:0]             sub_m2;
	logic [4:0]             close_k;

	always_comb begin
		lc      = to_lower(ch);
		sp      = is_space(ch);
		lvl_up  = (level == {LEVEL_WIDTH{1'b1}}) ? level : level + LEVEL_WIDTH'(1);
		lvl_dn  = (level == '0) ? level : level - LEVEL_WIDTH'(1);
		tim     = (pos.phase == PH_TIME);
		lon     = (pos.phase == PH_LON);
		len     = tim ? 5'd4 : 5'd3;
		sub     = pos.sub;
		sub_m1  = sub - 5'd1;
		sub_m2  = sub - 5'd2;
		close_k = sub - EX_CLOSE0;

		pos_nx   = pos;
		level_nx = level;
		res      = '0;

		if (en) begin
			case (pos.phase)
				PH_START: begin
					if (sub inside {[ST_NAME:5'd5]}) begin
						if (lc == trkpt_char(sub_m1[2:0])) begin
							pos_nx.sub = sub + 5'd1;
						end else begin
							pos_nx.sub = SS_IDLE;
							res.redo   = 1'b1;
						end
					end else if (sub == ST_WS) begin
						pos_nx.sub = SS_IDLE;
						res.redo   = 1'b1;
						if (sp) begin
							pos_nx.phase = PH_LAT;
							level_nx     = lvl_up;
						end
					end else begin
						pos_nx.sub = (ch == CH_LT) ? ST_NAME : SS_IDLE;
					end
				end
				PH_LAT, PH_LON: begin
					case (sub)
						AT_SPACE: begin
							if (!sp) begin
								if (lc == name_char(pos.phase, 3'd0)) begin
									pos_nx.sub = AT_N1;
								end else begin
									pos_nx.sub = SS_IDLE;
									res.redo   = 1'b1;
								end
							end
						end
						AT_N1, AT_N2: begin
							if (lc == name_char(pos.phase, sub_m1[2:0])) begin
								pos_nx.sub = sub + 5'd1;
							end else begin
								pos_nx.sub = SS_IDLE;
								res.redo   = 1'b1;
							end
						end
						AT_EQ: begin
							if (sp || ch == CH_EQ) begin
								pos_nx.sub = AT_OPEN;
							end else begin
								pos_nx.sub = SS_IDLE;
								res.redo   = 1'b1;
							end
						end
						AT_OPEN: begin
							if (ch == CH_DQ) begin
								pos_nx.sub = AT_DQ;
							end else if (ch == CH_SQ) begin
								pos_nx.sub = AT_SQ;
							end
						end
						AT_DQ: begin
							res.kind = EMIT_CHAR;
							if (ch == CH_DQ) begin
								res.ch     = CH_COMMA;
								pos_nx.sub = AT_AFTER;
							end else begin
								res.ch = ch;
							end
						end
						AT_SQ: begin
							res.kind = EMIT_CHAR;
							if (ch == CH_SQ) begin
								res.ch = CH_COMMA;
								if (lon) begin
									pos_nx.sub = AT_TAIL;
								end else begin
									pos_nx.phase = PH_LON;
									pos_nx.sub   = SS_IDLE;
								end
							end else begin
								res.ch = ch;
							end
						end
						AT_AFTER: begin
							if (lon) begin
								if (ch == CH_GT) begin
									pos_nx.sub = AT_GT;
								end
							end else if (ch == CH_SQ) begin
								pos_nx.sub = AT_SQ;
							end else begin
								pos_nx.phase = PH_LON;
								pos_nx.sub   = SS_IDLE;
								res.redo     = 1'b1;
							end
						end
						AT_GT: begin
							if (lon && ch == CH_SQ) begin
								pos_nx.sub = AT_SQ;
							end else begin
								pos_nx.phase = PH_ELE;
								pos_nx.sub   = SS_IDLE;
								res.redo     = 1'b1;
							end
						end
						AT_TAIL: begin
							if (ch == CH_GT) begin
								pos_nx.phase = PH_ELE;
								pos_nx.sub   = SS_IDLE;
							end
						end
						AT_SKIPD: begin
							if (ch == CH_DQ) begin
								pos_nx.sub = SS_IDLE;
							end
						end
						AT_SKIPS: begin
							if (ch == CH_SQ) begin
								pos_nx.sub = SS_IDLE;
							end
						end
						default: begin
							if (sp) begin
								pos_nx.sub = AT_SPACE;
							end else if (ch == CH_DQ) begin
								pos_nx.sub = AT_SKIPD;
							end else if (ch == CH_SQ) begin
								pos_nx.sub = AT_SKIPS;
							end else begin
								pos_nx.sub = SS_IDLE;
							end
						end
					endcase
				end
				PH_ELE, PH_TIME: begin
					if (sub == EL_LT) begin
						if (ch == CH_SLASH) begin
							level_nx   = lvl_dn;
							pos_nx.sub = SS_IDLE;
						end else begin
							level_nx = lvl_up;
							if (lc == name_char(pos.phase, 3'd0) &&
									lvl_up == LEVEL_WIDTH'(2)) begin
								pos_nx.sub = EL_NAME;
							end else begin
								pos_nx.sub = SS_IDLE;
								res.redo   = 1'b1;
							end
						end
					end else if (sub >= EL_NAME && sub <= len) begin
						if (lc == name_char(pos.phase, sub_m1[2:0])) begin
							pos_nx.sub = (sub == len) ? EX_SKIP1 : sub + 5'd1;
						end else begin
							pos_nx.sub = SS_IDLE;
							res.redo   = 1'b1;
						end
					end else if (sub >= EX_CLOSE0 && close_k < len) begin
						if (lc == name_char(pos.phase, close_k[2:0])) begin
							pos_nx.sub = (close_k + 5'd1 == len) ? EX_SKIPF : sub + 5'd1;
						end else begin
							pos_nx.sub = SS_IDLE;
							res.redo   = 1'b1;
						end
					end else begin
						case (sub)
							EX_SKIP1: begin
								if (ch == CH_GT) begin
									pos_nx.sub = EX_COPY;
								end
							end
							EX_COPY: begin
								if (ch == CH_LT) begin
									res.kind   = EMIT_CHAR;
									res.ch     = tim ? CH_NL : CH_COMMA;
									pos_nx.sub = EX_CLT;
								end else if (tim && ch == CH_COMMA) begin
									res.kind = EMIT_COMMA;
								end else begin
									res.kind = EMIT_CHAR;
									res.ch   = ch;
								end
							end
							EX_CLT: begin
								if (ch == CH_SLASH) begin
									level_nx   = lvl_dn;
									pos_nx.sub = EX_CLOSE0;
								end else begin
									pos_nx.sub = SS_IDLE;
									res.redo   = 1'b1;
								end
							end
							EX_SKIPF: begin
								if (ch == CH_GT) begin
									pos_nx.phase = tim ? PH_END : PH_TIME;
									pos_nx.sub   = SS_IDLE;
								end
							end
							EX_QD: begin
								if (ch == CH_DQ) begin
									pos_nx.sub = SS_IDLE;
								end
							end
							EX_QS: begin
								if (ch == CH_SQ) begin
									pos_nx.sub = SS_IDLE;
								end
							end
							default: begin
								if (ch == CH_LT) begin
									pos_nx.sub = EL_LT;
								end else if (ch == CH_DQ) begin
									pos_nx.sub = EX_QD;
								end else if (ch == CH_SQ) begin
									pos_nx.sub = EX_QS;
								end else begin
									pos_nx.sub = SS_IDLE;
								end
							end
						endcase
					end
				end
				PH_END: begin
					if (sub == EN_LT) begin
						if (ch == CH_SLASH) begin
							level_nx   = lvl_dn;
							pos_nx.sub = EN_NAME;
						end else begin
							pos_nx.sub = SS_IDLE;
							res.redo   = 1'b1;
						end
					end else if (sub inside {[EN_NAME:EN_LAST]}) begin
						if (lc == trkpt_char(sub_m2[2:0])) begin
							pos_nx.sub = sub + 5'd1;
						end else begin
							pos_nx.sub = SS_IDLE;
							res.redo   = 1'b1;
						end
					end else if (sub == EN_GT) begin
						if (ch == CH_GT) begin
							pos_nx.phase = PH_START;
							pos_nx.sub   = SS_IDLE;
						end
					end else begin
						pos_nx.sub = (ch == CH_LT) ? EN_LT : SS_IDLE;
					end
				end
				default: begin
					// unused phase code: restart the search and look again
					pos_nx.phase = PH_START;
					pos_nx.sub   = SS_IDLE;
					res.redo     = 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/gpx_trackpoint_csv_extractor.sv
`default_nettype none
// Streams GPX text in, one character per beat, and streams out one CSV line
// "lat,lon,ele,time" with a newline per trackpoint. An input beat can be taken
// every cycle while in_stall is low; it is held in the input register and what
// it emits in the output register. Most characters give one output beat or
// none, but a comma in the time text becomes the seven-beat "&comma;". The
// output register's beat counter steps through it, so it holds the output
// until all seven beats are taken, and a following character that emits
// waits in the input register, stalling the input side, until the last of
// those beats is taken. A stalled output likewise holds back the next
// character that emits; characters that emit nothing still advance. A character
// that ends a failed partial match is examined again within the same cycle by
// a chain of four copies of the matching logic. An end_of_stream beat flushes
// any pending separator as one output beat and resets the parser.
module gpx_trackpoint_csv_extractor import gtce_pkg::*; #(
	parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       final_of_run
);

	localparam int NPASS = 4;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// parser state
	gtce_pos_t              pos_q;
	logic [LEVEL_WIDTH-1:0] level_q;

	// output register
	logic       ov_q;
	logic       ocomma_q;
	logic [7:0] och_q;
	logic [2:0] oidx_q;

	gtce_pos_t              pos_c [NPASS+1];
	logic [LEVEL_WIDTH-1:0] lvl_c [NPASS+1];
	gtce_pass_t             res_c [NPASS];
	logic                   en_c  [NPASS];

	gtce_pos_t              pos_nx;
	logic [LEVEL_WIDTH-1:0] level_nx;
	logic [1:0]             emit_kind;
	logic [7:0]             emit_ch;
	logic                   in_take;
	logic                   out_take;
	logic                   out_free;
	logic                   advance;

	assign pos_c[0] = pos_q;
	assign lvl_c[0] = level_q;

	genvar g;
	generate
		for (g = 0; g < NPASS; g++) begin : g_pass
			if (g == 0) begin : g_first
				assign en_c[g] = 1'b1;
			end else begin : g_next
				assign en_c[g] = res_c[g-1].redo;
			end
			gtce_pass #(
				.LEVEL_WIDTH(LEVEL_WIDTH)
			) u_pass (
				.en       (en_c[g]),
				.ch       (byte_s1),
				.pos      (pos_c[g]),
				.level    (lvl_c[g]),
				.pos_nx   (pos_c[g+1]),
				.level_nx (lvl_c[g+1]),
				.res      (res_c[g])
			);
		end
	endgenerate

	always_comb begin
		emit_kind = EMIT_NONE;
		emit_ch   = '0;
		pos_nx    = pos_c[NPASS];
		level_nx  = lvl_c[NPASS];
		if (eos_s1) begin
			// flush the separator of a value still being copied, then reset
			pos_nx   = '{phase: PH_START, sub: SS_IDLE};
			level_nx = '0;
			if ((pos_q.phase == PH_LAT || pos_q.phase == PH_LON) &&
					(pos_q.sub == AT_DQ || pos_q.sub == AT_SQ)) begin
				emit_kind = EMIT_CHAR;
				emit_ch   = CH_COMMA;
			end else if (pos_q.phase == PH_ELE && pos_q.sub == EX_COPY) begin
				emit_kind = EMIT_CHAR;
				emit_ch   = CH_COMMA;
			end else if (pos_q.phase == PH_TIME && pos_q.sub == EX_COPY) begin
				emit_kind = EMIT_CHAR;
				emit_ch   = CH_NL;
			end
		end else begin
			// at most one pass emits, the others leave zeros
			for (int i = 0; i < NPASS; i++) begin
				emit_kind = emit_kind | res_c[i].kind;
				emit_ch   = emit_ch | res_c[i].ch;
			end
		end
	end

	assign out_valid    = ov_q;
	assign out_byte     = ocomma_q ? comma_char(oidx_q) : och_q;
	assign final_of_run = !ocomma_q || (oidx_q == COMMA_LAST);

	assign out_take = ov_q && !out_stall;
	assign out_free = !ov_q || (out_take && final_of_run);
	assign advance  = v_s1 && ((emit_kind == EMIT_NONE) || out_free);
	assign in_stall = v_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_take || (v_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '{phase: PH_START, sub: SS_IDLE};
			level_q <= '0;
		end else if (advance) begin
			pos_q   <= pos_nx;
			level_q <= level_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			oidx_q <= '0;
		end else if (advance && emit_kind != EMIT_NONE) begin
			ov_q   <= 1'b1;
			oidx_q <= '0;
		end else if (out_take) begin
			// step through the replacement text, drop the beat when done
			if (final_of_run) begin
				ov_q <= 1'b0;
			end else begin
				oidx_q <= oidx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_kind != EMIT_NONE) begin
			ocomma_q <= (emit_kind == EMIT_COMMA);
			och_q    <= emit_ch;
		end
	end

endmodule
`default_nettype wire

// File: hdl/gtce_checker.sv
`default_nettype none
`include "gpx_trackpoint_csv_extractor_macros.svh"
module gtce_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       final_of_run
);

	logic mid_beat;
	assign mid_beat = out_valid && !out_stall && !final_of_run;

	`GTCE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(final_of_run))

	// a run of the comma replacement never breaks off
	`GTCE_ASSERT_NEXT(a_run_continues, clk, arst_n, mid_beat, out_valid)

	// the replacement text starts with "&c"
	`GTCE_ASSERT_NEXT(a_amp_then_c, clk, arst_n, mid_beat && out_byte == 8'h26, out_byte == 8'h63)

	// only the replacement text has beats that are not final, and ';' ends it
	`GTCE_ASSERT_NOW(a_semi_final, clk, arst_n, out_valid && out_byte == 8'h3B, final_of_run)

endmodule

bind gpx_trackpoint_csv_extractor gtce_checker u_gtce_checker (.*);
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
	import gtce_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_LINE_BEATS = 7;
	localparam int MAX_RESCANS = 4;

	typedef struct packed {
		logic [7:0] ch;
		logic       ends_run;
	} csv_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'd0;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       final_of_run;

	gpx_trackpoint_csv_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.final_of_run (final_of_run)
	);

	// parser state of the predictor
	logic [2:0] scan_phase = PH_START;
	logic [4:0] scan_step = SS_IDLE;
	logic [7:0] nest_level = 8'd0;
	logic [7:0] line_bytes[$];

	csv_beat_t  csv_expected[$];
	logic [7:0] gpx_text[$];

	int mismatch_count = 0;
	int beats_sent = 0;
	int cycle_count = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	logic [7:0] trkpt_word [5] = '{"t", "r", "k", "p", "t"};
	logic [7:0] lat_word [3] = '{"l", "a", "t"};
	logic [7:0] lon_word [3] = '{"l", "o", "n"};
	logic [7:0] ele_word [3] = '{"e", "l", "e"};
	logic [7:0] time_word [4] = '{"t", "i", "m", "e"};
	logic [7:0] comma_entity [7] = '{"&", "c", "o", "m", "m", "a", ";"};
	logic [7:0] blank_chars [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
	string value_chars = "0123456789.-:TZ";
	string decoy_attrs [4] = '{"ver=\"lat=1\" ", "src='lon' ", "la=\"0\" ", "latx=\"5\" "};
	string decoy_elems [4] = '{"<name>ab</name>", "<ext><ele>9</ele><time>8</time></ext>",
		"\"<ele>7</ele>\"", "'<time>x</time>'"};

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// ---------------- predictor ----------------

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void put_char(input logic [7:0] c);
		if (line_bytes.size() < MAX_LINE_BEATS)
			line_bytes.push_back(c);
	endfunction

	function automatic void level_up();
		if (nest_level != 8'hFF)
			nest_level++;
	endfunction

	function automatic void level_down();
		if (nest_level != 8'h00)
			nest_level--;
	endfunction

	function automatic void reset_scanner();
		scan_phase = PH_START;
		scan_step = SS_IDLE;
		nest_level = 8'd0;
	endfunction

	// each scan function returns 1 when the character must be looked at again
	function automatic bit scan_start(input logic [7:0] c);
		if (scan_step >= ST_NAME && scan_step <= 5'd5) begin
			if (fold_case(c) == trkpt_word[scan_step - 1]) begin
				scan_step++;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		if (scan_step == ST_WS) begin
			scan_step = SS_IDLE;
			if (is_blank(c)) begin
				scan_phase = PH_LAT;
				level_up();
			end
			return 1'b1;
		end
		scan_step = (c == CH_LT) ? ST_NAME : SS_IDLE;
		return 1'b0;
	endfunction

	function automatic bit scan_attr(input logic [7:0] c, input bit lon);
		logic [7:0] lc;
		logic [7:0] want;
		lc = fold_case(c);
		want = 8'd0;
		if (scan_step >= 5'd1 && scan_step <= 5'd3)
			want = lon ? lon_word[scan_step - 1] : lat_word[scan_step - 1];
		case (scan_step)
			AT_SPACE: begin
				if (is_blank(c))
					return 1'b0;
				if (lc == want) begin
					scan_step = AT_N1;
					return 1'b0;
				end
				scan_step = SS_IDLE;
				return 1'b1;
			end
			AT_N1, AT_N2: begin
				if (lc == want) begin
					scan_step++;
					return 1'b0;
				end
				scan_step = SS_IDLE;
				return 1'b1;
			end
			AT_EQ: begin
				if (is_blank(c) || c == CH_EQ) begin
					scan_step = AT_OPEN;
					return 1'b0;
				end
				scan_step = SS_IDLE;
				return 1'b1;
			end
			AT_OPEN: begin
				if (c == CH_DQ)
					scan_step = AT_DQ;
				else if (c == CH_SQ)
					scan_step = AT_SQ;
				return 1'b0;
			end
			AT_DQ: begin
				if (c == CH_DQ) begin
					put_char(CH_COMMA);
					scan_step = AT_AFTER;
				end else
					put_char(c);
				return 1'b0;
			end
			AT_SQ: begin
				if (c == CH_SQ) begin
					put_char(CH_COMMA);
					if (lon)
						scan_step = AT_TAIL;
					else begin
						scan_phase = PH_LON;
						scan_step = SS_IDLE;
					end
				end else
					put_char(c);
				return 1'b0;
			end
			AT_AFTER: begin
				if (lon) begin
					if (c == CH_GT)
						scan_step = AT_GT;
					return 1'b0;
				end
				if (c == CH_SQ) begin
					scan_step = AT_SQ;
					return 1'b0;
				end
				scan_phase = PH_LON;
				scan_step = SS_IDLE;
				return 1'b1;
			end
			AT_GT: begin
				if (lon && c == CH_SQ) begin
					scan_step = AT_SQ;
					return 1'b0;
				end
				scan_phase = PH_ELE;
				scan_step = SS_IDLE;
				return 1'b1;
			end
			AT_TAIL: begin
				if (c == CH_GT) begin
					scan_phase = PH_ELE;
					scan_step = SS_IDLE;
				end
				return 1'b0;
			end
			AT_SKIPD: begin
				if (c == CH_DQ)
					scan_step = SS_IDLE;
				return 1'b0;
			end
			AT_SKIPS: begin
				if (c == CH_SQ)
					scan_step = SS_IDLE;
				return 1'b0;
			end
			default: begin
				if (is_blank(c))
					scan_step = AT_SPACE;
				else if (c == CH_DQ)
					scan_step = AT_SKIPD;
				else if (c == CH_SQ)
					scan_step = AT_SKIPS;
				else
					scan_step = SS_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [7:0] elem_letter(input bit tim, input int k);
		return tim ? time_word[k] : ele_word[k];
	endfunction

	function automatic bit scan_elem(input logic [7:0] c, input bit tim);
		int len;
		int k;
		logic [7:0] lc;
		len = tim ? 4 : 3;
		lc = fold_case(c);
		if (scan_step == EL_LT) begin
			if (c == CH_SLASH) begin
				level_down();
				scan_step = SS_IDLE;
				return 1'b0;
			end
			level_up();
			if (lc == elem_letter(tim, 0) && nest_level == 8'd2) begin
				scan_step = EL_NAME;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		if (scan_step >= EL_NAME && scan_step <= len) begin
			if (lc == elem_letter(tim, scan_step - 1)) begin
				scan_step = (scan_step == len) ? EX_SKIP1 : scan_step + 5'd1;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		if (scan_step >= EX_CLOSE0 && scan_step < EX_CLOSE0 + len) begin
			k = scan_step - EX_CLOSE0;
			if (lc == elem_letter(tim, k)) begin
				scan_step = (k + 1 == len) ? EX_SKIPF : scan_step + 5'd1;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		case (scan_step)
			EX_SKIP1: begin
				if (c == CH_GT)
					scan_step = EX_COPY;
			end
			EX_COPY: begin
				if (c == CH_LT) begin
					put_char(tim ? CH_NL : CH_COMMA);
					scan_step = EX_CLT;
				end else if (tim && c == CH_COMMA) begin
					foreach (comma_entity[i])
						put_char(comma_entity[i]);
				end else
					put_char(c);
			end
			EX_CLT: begin
				if (c == CH_SLASH) begin
					level_down();
					scan_step = EX_CLOSE0;
					return 1'b0;
				end
				scan_step = SS_IDLE;
				return 1'b1;
			end
			EX_SKIPF: begin
				if (c == CH_GT) begin
					scan_phase = tim ? PH_END : PH_TIME;
					scan_step = SS_IDLE;
				end
			end
			EX_QD: begin
				if (c == CH_DQ)
					scan_step = SS_IDLE;
			end
			EX_QS: begin
				if (c == CH_SQ)
					scan_step = SS_IDLE;
			end
			default: begin
				if (c == CH_LT)
					scan_step = EL_LT;
				else if (c == CH_DQ)
					scan_step = EX_QD;
				else if (c == CH_SQ)
					scan_step = EX_QS;
				else
					scan_step = SS_IDLE;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic bit scan_end(input logic [7:0] c);
		if (scan_step == EN_LT) begin
			if (c == CH_SLASH) begin
				level_down();
				scan_step = EN_NAME;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		if (scan_step >= EN_NAME && scan_step <= EN_LAST) begin
			if (fold_case(c) == trkpt_word[scan_step - 2]) begin
				scan_step++;
				return 1'b0;
			end
			scan_step = SS_IDLE;
			return 1'b1;
		end
		if (scan_step == EN_GT) begin
			if (c == CH_GT) begin
				scan_phase = PH_START;
				scan_step = SS_IDLE;
			end
			return 1'b0;
		end
		scan_step = (c == CH_LT) ? EN_LT : SS_IDLE;
		return 1'b0;
	endfunction

	function automatic bit scan_char(input logic [7:0] c);
		case (scan_phase)
			PH_START: return scan_start(c);
			PH_LAT:   return scan_attr(c, 1'b0);
			PH_LON:   return scan_attr(c, 1'b1);
			PH_ELE:   return scan_elem(c, 1'b0);
			PH_TIME:  return scan_elem(c, 1'b1);
			PH_END:   return scan_end(c);
			default: begin
				scan_phase = PH_START;
				scan_step = SS_IDLE;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic predict_csv_beats(input logic [7:0] ch, input bit eos);
		csv_beat_t beat;
		line_bytes.delete();
		if (eos) begin
			// flush the separator of a value still being copied
			if ((scan_phase == PH_LAT || scan_phase == PH_LON)
					&& (scan_step == AT_DQ || scan_step == AT_SQ))
				put_char(CH_COMMA);
			else if (scan_phase == PH_ELE && scan_step == EX_COPY)
				put_char(CH_COMMA);
			else if (scan_phase == PH_TIME && scan_step == EX_COPY)
				put_char(CH_NL);
			reset_scanner();
		end else begin
			for (int pass = 0; pass < MAX_RESCANS; pass++)
				if (!scan_char(ch))
					break;
		end
		foreach (line_bytes[i]) begin
			beat.ch = line_bytes[i];
			beat.ends_run = (i == line_bytes.size() - 1);
			csv_expected.push_back(beat);
		end
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		csv_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (csv_expected.size() == 0) begin
				report_mismatch("beat with nothing pending", out_byte, 8'h00);
			end else begin
				want = csv_expected.pop_front();
				if (out_byte !== want.ch)
					report_mismatch("out_byte", out_byte, want.ch);
				if (final_of_run !== want.ends_run)
					report_mismatch("final_of_run", {7'd0, final_of_run},
						{7'd0, want.ends_run});
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_beat(input logic [7:0] ch, input bit eos);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= eos ? 8'($urandom_range(255)) : ch;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		predict_csv_beats(ch, eos);
		beats_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < gpx_text.size(); i++)
			send_beat(gpx_text[i], 1'b0);
		gpx_text.delete();
	endtask

	task automatic send_end_of_stream();
		send_beat(8'd0, 1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (csv_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		in_idle_pct = send_pct;
		out_stall_pct = stall_pct;
	endtask

	function automatic void add_word(input string w);
		for (int i = 0; i < w.len(); i++)
			gpx_text.push_back(w[i]);
	endfunction

	// scramble letter case
	function automatic void add_name(input string w);
		logic [7:0] c;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (c >= "a" && c <= "z" && $urandom_range(1))
				c = c - 8'd32;
			gpx_text.push_back(c);
		end
	endfunction

	function automatic void add_blanks(input int lo, input int hi);
		repeat ($urandom_range(hi, lo))
			gpx_text.push_back(blank_chars[$urandom_range(5)]);
	endfunction

	// value text never holds a quote or '<'
	function automatic void add_value(input bit for_time);
		int r;
		repeat ($urandom_range(8, 1)) begin
			r = $urandom_range(15);
			if (r < (for_time ? 4 : 2))
				gpx_text.push_back(CH_COMMA);
			else if (r == 15)
				gpx_text.push_back(8'($urandom_range(255, 128)));
			else
				gpx_text.push_back(value_chars[$urandom_range(value_chars.len() - 1)]);
		end
	endfunction

	function automatic bit add_attr_value();
		bit dq;
		dq = $urandom_range(1);
		case ($urandom_range(2))
			0: add_word("=");
			1: add_word(" =");
			default: add_word("\t");
		endcase
		gpx_text.push_back(dq ? CH_DQ : CH_SQ);
		add_value(1'b0);
		gpx_text.push_back(dq ? CH_DQ : CH_SQ);
		return dq;
	endfunction

	function automatic void add_quoted_extra();
		gpx_text.push_back(CH_SQ);
		add_value(1'b0);
		gpx_text.push_back(CH_SQ);
	endfunction

	function automatic void add_element(input string name, input bit for_time);
		bit broken;
		broken = ($urandom_range(5) == 0);
		add_word("<");
		add_name(name);
		if ($urandom_range(3) == 0)
			add_word(" src=\"a\"");
		add_word(">");
		add_value(for_time);
		if (broken) begin
			// separator goes out, then the close fails and the search resumes
			if ($urandom_range(1)) begin
				add_word("</");
				add_word(name.substr(0, 1));
				add_word("x>");
			end else
				add_word("<b></b>");
			add_word("<");
			add_name(name);
			add_word(">");
			add_value(for_time);
		end
		add_word("</");
		add_name(name);
		add_blanks(0, 1);
		add_word(">");
	endfunction

	function automatic void compose_trackpoint();
		bit lat_dq;
		bit lon_dq;
		repeat ($urandom_range(2))
			gpx_text.push_back(8'($urandom_range(255)));
		add_word("<");
		add_name("trkpt");
		add_blanks(1, 2);
		if ($urandom_range(3) == 0)
			add_word(decoy_attrs[$urandom_range(3)]);
		add_name("lat");
		lat_dq = add_attr_value();
		if (lat_dq && $urandom_range(3) == 0)
			add_quoted_extra();
		add_blanks(1, 2);
		if ($urandom_range(3) == 0)
			add_word(decoy_attrs[$urandom_range(3)]);
		add_name("lon");
		lon_dq = add_attr_value();
		add_blanks(0, 1);
		add_word(">");
		if (lon_dq && $urandom_range(3) == 0) begin
			add_quoted_extra();
			add_word(">");
		end
		add_blanks(0, 2);
		if ($urandom_range(3) == 0)
			add_word(decoy_elems[$urandom_range(3)]);
		add_element("ele", 1'b0);
		add_blanks(0, 2);
		if ($urandom_range(3) == 0)
			add_word(decoy_elems[$urandom_range(3)]);
		add_element("time", 1'b1);
		// extra close tags drive the level down to its floor
		if ($urandom_range(3) == 0)
			add_word("<extensions><x>1</x></extensions>");
		add_blanks(0, 2);
		add_word("</");
		add_name("trkpt");
		add_word(">");
		add_blanks(0, 1);
	endfunction

	// ---------------- tests ----------------

	task automatic test_field_extremes();
		gpx_text = '{8'h00, 8'hFF, 8'h80, 8'h7F, CH_LT, 8'hFF, CH_LT};
		send_text();
		send_end_of_stream();
		send_end_of_stream();
	endtask

	task automatic test_compact_trackpoint();
		add_word("<TrKpT\tLAT=\"1\"'x' lon=\"2\">'y'><ele>5</elx><ele>6</ELE>");
		add_word("<time>a,b</time></trkpt>");
		send_text();
		send_end_of_stream();
	endtask

	task automatic test_flush_on_end();
		add_word("<trkpt lat=\"7");
		send_text();
		send_end_of_stream();
		add_word("<trkpt lat='1' lon='2'><ele>3");
		send_text();
		send_end_of_stream();
	endtask

	task automatic test_level_saturation();
		// try to push the level below its floor, then climb back so ele sits at two
		add_word("<trkpt lat=\"\" lon=\"\">");
		add_word("</</</<a");
		add_word("<ele>9</ele><time>1</time></trkpt>");
		send_text();
		send_end_of_stream();
	endtask

	task automatic test_random_text(input int target);
		int first;
		int cut;
		first = beats_sent;
		while (beats_sent - first < target) begin
			case ($urandom_range(9))
				0: begin
					repeat ($urandom_range(16, 4))
						gpx_text.push_back(8'($urandom_range(255)));
					send_text();
				end
				1: begin
					// break off mid trackpoint
					compose_trackpoint();
					cut = $urandom_range(gpx_text.size() - 1, 1);
					while (gpx_text.size() > cut)
						void'(gpx_text.pop_back());
					send_text();
					send_end_of_stream();
				end
				default: begin
					compose_trackpoint();
					send_text();
					if ($urandom_range(4) == 0)
						send_end_of_stream();
				end
			endcase
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		reset_scanner();

		set_idling(0, 0);
		test_field_extremes();
		test_compact_trackpoint();
		test_flush_on_end();
		test_level_saturation();
		wait_drained();

		set_idling(81, 0);
		test_random_text(40);
		wait_drained();

		set_idling(0, 81);
		test_random_text(40);
		wait_drained();

		set_idling(29, 29);
		test_random_text(40);
		wait_drained();

		if (mismatch_count == 0 && csv_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// File: gpx_trackpoint_csv_extractor.f
+incdir+hdl
hdl/gtce_pkg.sv
hdl/gtce_pass.sv
hdl/gpx_trackpoint_csv_extractor.sv
hdl/gtce_checker.sv
test/testbench.sv
